FILE: rtl/ypsc_pkg.sv
package ypsc_pkg;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_QUEST = 8'h3f;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_HASH  = 8'h23;

	localparam logic [2:0] POS_MAX = 3'd7;

	// scan state carried from one byte to the next
	typedef struct packed {
		logic [2:0] byte_position;
		logic [7:0] first_char;
		logic [7:0] previous_char;
		logic       rejected;
		logic       marker_candidate;
	} scan_state_t;

	localparam scan_state_t STATE_RESET = '{
		byte_position:    3'd0,
		first_char:       8'h00,
		previous_char:    8'h00,
		rejected:         1'b0,
		marker_candidate: 1'b1
	};

	// one byte beat as seen by the rule logic
	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
		logic       empty_string;
	} scan_beat_t;

	// outcome of one byte beat
	typedef struct packed {
		scan_state_t next_state;
		logic        has_result;
		logic        plain_ok;
	} scan_step_t;

	function automatic logic blank_byte(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic reserved_head(input logic [7:0] c);
		logic hit;
		unique case (c)
			8'h2c, 8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h23, 8'h26, 8'h2a,
			8'h21, 8'h7c, 8'h3e, 8'h27, 8'h22, 8'h25, 8'h40, 8'h60: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

FILE: rtl/ypsc_byte_if.sv
interface ypsc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;
	logic       empty_string;

	modport source (output valid, output text_byte, output last_byte, output empty_string,
		input ready);
	modport sink (input valid, input text_byte, input last_byte, input empty_string,
		output ready);
endinterface

FILE: rtl/ypsc_verdict_if.sv
interface ypsc_verdict_if;
	logic valid;
	logic ready;
	logic plain_ok;

	modport source (output valid, output plain_ok, input ready);
	modport sink (input valid, input plain_ok, output ready);
endinterface

FILE: rtl/yaml_plain_scalar_checker.sv
// Checks whether a string may be written as a YAML plain scalar. The string
// arrives one byte per beat on the bytes channel, its final byte marked by
// last_byte, or as a single beat with empty_string set for a zero-length
// string. Exactly one beat leaves on the verdict channel per string, after
// the final (or empty) beat: plain_ok = 1 means no quoting is needed. A
// beat is taken every cycle; a string's verdict is registered in the result
// register after its last byte leaves the input register; only a verdict
// still waiting on a held-off verdict channel stalls the input. The
// scan keeps just the first byte, the previous byte, a saturating position
// count and two flags, so throughput is set by a single rule evaluation
// per cycle between the input register and the scan state.
module yaml_plain_scalar_checker
	import ypsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ypsc_byte_if.sink             bytes,
	ypsc_verdict_if.source        verdict
);

	// input register stage
	logic        valid_s1;
	scan_beat_t  beat_s1;

	// scan state and result register
	scan_state_t state_q;
	logic        out_valid_q;
	logic        out_plain_ok_q;

	scan_step_t  step;
	logic        advance;
	logic        in_take;

	ypsc_rules u_rules (
		.state (state_q),
		.beat  (beat_s1),
		.step  (step)
	);

	// a beat without a verdict always moves on; a verdict needs a free
	// result register or one being drained this cycle
	assign advance = valid_s1 && (!step.has_result || !out_valid_q || verdict.ready);
	assign bytes.ready = !valid_s1 || advance;
	assign in_take = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			beat_s1.text_byte    <= bytes.text_byte;
			beat_s1.last_byte    <= bytes.last_byte;
			beat_s1.empty_string <= bytes.empty_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= step.next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step.has_result) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.has_result) begin
			out_plain_ok_q <= step.plain_ok;
		end
	end

	assign verdict.valid    = out_valid_q;
	assign verdict.plain_ok = out_plain_ok_q;

	// a pending verdict is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !verdict.ready) |-> !(advance && step.has_result))
		else $error("verdict overwritten while stalled");

	// the scan state starts over after every verdict
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step.has_result) |=> (state_q == STATE_RESET))
		else $error("scan state not cleared after end of string");

	// an empty string is never plain
	a_empty_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && beat_s1.empty_string) |=> (out_valid_q && !out_plain_ok_q))
		else $error("empty string reported as plain");

endmodule

FILE: rtl/ypsc_rules.sv
module ypsc_rules
	import ypsc_pkg::*;
(
	input  scan_state_t state,
	input  scan_beat_t  beat,
	output scan_step_t  step
);

	logic [7:0]  c;
	logic        bad;
	logic        mark;
	logic        lead_ind;
	scan_state_t upd;

	assign c = beat.text_byte;
	assign lead_ind = (state.first_char == CH_DASH) || (state.first_char == CH_QUEST);

	always_comb begin
		bad  = state.rejected;
		mark = state.marker_candidate;
		upd  = state;

		if (state.byte_position == 3'd0) begin
			if (blank_byte(c) || reserved_head(c))
				bad = 1'b1;
			if (((c == CH_DASH) || (c == CH_QUEST)) && beat.last_byte)
				bad = 1'b1;
			if ((c != CH_DASH) && (c != CH_DOT))
				mark = 1'b0;
			upd.first_char = c;
		end else begin
			// indicator followed by a blank
			if ((state.byte_position == 3'd1) && lead_ind && blank_byte(c))
				bad = 1'b1;
			if ((state.previous_char == CH_COLON) && blank_byte(c))
				bad = 1'b1;
			// comment start after a blank
			if ((c == CH_HASH) && blank_byte(state.previous_char))
				bad = 1'b1;
			if ((state.byte_position >= 3'd3) || (c != state.first_char))
				mark = 1'b0;
		end

		if ((c == CH_TAB) || (c == CH_LF) || (c == CH_CR))
			bad = 1'b1;
		if ((c == CH_COLON) && beat.last_byte)
			bad = 1'b1;

		if (beat.last_byte) begin
			if (blank_byte(c))
				bad = 1'b1;
			// exactly three marker bytes
			if ((state.byte_position == 3'd2) && mark)
				bad = 1'b1;
		end

		upd.rejected         = bad;
		upd.marker_candidate = mark;
		upd.previous_char    = c;
		if (state.byte_position != POS_MAX)
			upd.byte_position = state.byte_position + 3'd1;

		if (beat.empty_string) begin
			step.next_state = STATE_RESET;
			step.has_result = 1'b1;
			step.plain_ok   = 1'b0;
		end else if (beat.last_byte) begin
			step.next_state = STATE_RESET;
			step.has_result = 1'b1;
			step.plain_ok   = ~bad;
		end else begin
			step.next_state = upd;
			step.has_result = 1'b0;
			step.plain_ok   = 1'b0;
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
	import ypsc_pkg::*;

	// one row of the directed table; known_ok marks rows whose verdict is typed in
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       nul;
		logic       known_ok;
		logic       want_ok;
	} probe_row_t;

	localparam int PROBE_ROWS = 24;
	localparam int RANDOM_BEATS = 1600;
	localparam int DRAIN_EVERY = 400;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_LBRACKET = 8'h5b;

	// directed strings: extremes, several reject rules, the document markers, an aborted string
	localparam probe_row_t PROBES [PROBE_ROWS] = '{
		'{8'h00,       1'b0, 1'b1, 1'b1, 1'b0}, // empty string
		'{CH_LOW_A,    1'b1, 1'b0, 1'b1, 1'b1}, // "a"
		'{CH_SPACE,    1'b1, 1'b0, 1'b1, 1'b0}, // lone space
		'{CH_LBRACKET, 1'b1, 1'b0, 1'b1, 1'b0}, // reserved indicator first
		'{CH_DASH,     1'b1, 1'b0, 1'b1, 1'b0}, // lone dash
		'{CH_QUEST,    1'b0, 1'b0, 1'b0, 1'b0}, // "? x"
		'{CH_SPACE,    1'b0, 1'b0, 1'b0, 1'b0},
		'{CH_LOW_X,    1'b1, 1'b0, 1'b1, 1'b0},
		'{CH_DASH,     1'b0, 1'b0, 1'b0, 1'b0}, // "---"
		'{CH_DASH,     1'b0, 1'b0, 1'b0, 1'b0},
		'{CH_DASH,     1'b1, 1'b0, 1'b1, 1'b0},
		'{CH_DOT,      1'b0, 1'b0, 1'b0, 1'b0}, // ".." is not a marker
		'{CH_DOT,      1'b1, 1'b0, 1'b0, 1'b0},
		'{CH_LOW_A,    1'b0, 1'b0, 1'b0, 1'b0}, // line feed inside
		'{CH_LF,       1'b1, 1'b0, 1'b1, 1'b0},
		'{CH_LOW_A,    1'b0, 1'b0, 1'b0, 1'b0}, // colon at the end
		'{CH_COLON,    1'b1, 1'b0, 1'b1, 1'b0},
		'{CH_LOW_A,    1'b0, 1'b0, 1'b0, 1'b0}, // "a #" comment
		'{CH_SPACE,    1'b0, 1'b0, 1'b0, 1'b0},
		'{CH_HASH,     1'b1, 1'b0, 1'b1, 1'b0},
		'{8'hff,       1'b0, 1'b0, 1'b0, 1'b0}, // high bytes pass
		'{8'h80,       1'b1, 1'b0, 1'b1, 1'b1},
		'{8'h00,       1'b1, 1'b0, 1'b1, 1'b1}, // lone zero byte
		'{CH_LOW_X,    1'b0, 1'b0, 1'b0, 1'b0}  // aborted by the empty beat appended below
	};

	logic clk = 1'b0;
	logic arst_n;

	ypsc_byte_if    byte_ch();
	ypsc_verdict_if verdict_ch();

	yaml_plain_scalar_checker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.verdict (verdict_ch)
	);

	always #5 clk = ~clk;

	// predicted scan state, mirrors the block between beats
	logic [2:0] scan_pos;
	logic [7:0] head_char;
	logic [7:0] prior_char;
	logic       reject_seen;
	logic       dash_dot_run;

	// verdicts still owed by the block, oldest first
	logic verdict_q [$];

	int error_count = 0;
	int beats_sent = 0;
	int verdicts_seen = 0;
	int plain_seen = 0;
	bit no_idle = 1'b0;

	function automatic logic space_or_tab(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB;
	endfunction

	function automatic void clear_scan();
		scan_pos = 3'd0;
		head_char = 8'h00;
		prior_char = 8'h00;
		reject_seen = 1'b0;
		dash_dot_run = 1'b1;
	endfunction

	// rule evaluation for one accepted beat; fills produced/ok at a string end
	function automatic void predict_verdict(input logic [7:0] ch, input logic fin,
			input logic nul, output logic produced, output logic ok);
		logic bad;
		logic mark;
		bad = reject_seen;
		mark = dash_dot_run;
		produced = 1'b0;
		ok = 1'b0;
		if (nul) begin
			// empty string: always quoted, drops any partial string
			produced = 1'b1;
			clear_scan();
			return;
		end
		if (scan_pos == 3'd0) begin
			// indicators reserved as a first byte: , [ ] { } # & * ! | > ' " % @ backquote
			case (ch)
				8'h2c, 8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h23, 8'h26, 8'h2a,
				8'h21, 8'h7c, 8'h3e, 8'h27, 8'h22, 8'h25, 8'h40, 8'h60: bad = 1'b1;
				default: ;
			endcase
			if (space_or_tab(ch))
				bad = 1'b1;
			if ((ch == CH_DASH || ch == CH_QUEST) && fin)
				bad = 1'b1;
			if (ch != CH_DASH && ch != CH_DOT)
				mark = 1'b0;
			head_char = ch;
		end else begin
			// dash or question mark followed by a blank
			if (scan_pos == 3'd1 && (head_char == CH_DASH || head_char == CH_QUEST)
					&& space_or_tab(ch))
				bad = 1'b1;
			if (prior_char == CH_COLON && space_or_tab(ch))
				bad = 1'b1;
			if (ch == CH_HASH && space_or_tab(prior_char))
				bad = 1'b1;
			if (scan_pos >= 3'd3 || ch != head_char)
				mark = 1'b0;
		end
		if (ch == CH_TAB || ch == CH_LF || ch == CH_CR)
			bad = 1'b1;
		if (ch == CH_COLON && fin)
			bad = 1'b1;
		if (fin) begin
			// trailing blank, or exactly three dashes or three dots
			if (space_or_tab(ch))
				bad = 1'b1;
			if (scan_pos == 3'd2 && mark)
				bad = 1'b1;
			produced = 1'b1;
			ok = !bad;
			clear_scan();
		end else begin
			reject_seen = bad;
			dash_dot_run = mark;
			prior_char = ch;
			if (scan_pos < POS_MAX)
				scan_pos = scan_pos + 3'd1;
		end
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// byte content biased toward the characters the rules care about
	function automatic logic [7:0] pick_char();
		logic [7:0] hot [16];
		int r;
		hot = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_DASH, CH_DOT, CH_QUEST, CH_COLON,
			CH_HASH, 8'h2c, 8'h5b, 8'h7d, 8'h26, 8'h22, 8'h60, 8'h7c};
		r = $urandom_range(0, 9);
		if (r < 5)
			return hot[$urandom_range(0, 15)];
		else if (r < 8)
			return CH_LOW_A + 8'($urandom_range(0, 25));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	// drive one beat, wait for the handshake, predict, then idle
	task automatic put_beat(input logic [7:0] ch, input logic fin, input logic nul,
			input logic known_ok, input logic want_ok);
		logic produced;
		logic ok;
		int gap;
		byte_ch.valid <= 1'b1;
		byte_ch.text_byte <= ch;
		byte_ch.last_byte <= fin;
		byte_ch.empty_string <= nul;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		beats_sent++;
		predict_verdict(ch, fin, nul, produced, ok);
		if (produced)
			verdict_q.push_back(known_ok ? want_ok : ok);
		gap = no_idle ? 0 : idle_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every owed verdict is back
	task automatic drain_verdicts();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// one random string: mostly well formed, some markers, some broken
	task automatic send_random_string();
		int r;
		int n;
		logic [7:0] ch;
		r = $urandom_range(0, 99);
		no_idle = ($urandom_range(0, 4) == 0);
		if (r < 6) begin
			// empty string beat with junk in the ignored fields
			put_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0);
		end else if (r < 12) begin
			// three dashes or dots, and near misses of them
			n = $urandom_range(2, 4);
			for (int i = 0; i < n; i++) begin
				ch = ($urandom_range(0, 1) != 0) ? CH_DASH : CH_DOT;
				if (i > 0)
					ch = ($urandom_range(0, 5) == 0) ? pick_char() : head_char;
				put_beat(ch, i == n - 1, 1'b0, 1'b0, 1'b0);
			end
		end else if (r < 16) begin
			// string cut short by an empty beat
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				put_beat(pick_char(), 1'b0, 1'b0, 1'b0, 1'b0);
			put_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0);
		end else begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				put_beat(pick_char(), i == n - 1, 1'b0, 1'b0, 1'b0);
		end
	endtask

	// verdict checker, samples on the handshake edge
	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected verdict beat: plain_ok %0b", verdict_ch.plain_ok);
				error_count++;
			end else begin
				logic want;
				want = verdict_q.pop_front();
				verdicts_seen++;
				if (verdict_ch.plain_ok)
					plain_seen++;
				if (verdict_ch.plain_ok !== want) begin
					$error("plain_ok mismatch: expected %0b, got %0b", want, verdict_ch.plain_ok);
					error_count++;
				end
			end
		end
	end

	// verdict side backpressure, with long stretches of no stall now and then
	initial begin
		verdict_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int gap;
			verdict_ch.ready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(100, 300)) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
			gap = idle_gap();
			if (gap > 0) begin
				verdict_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// main sequence: reset, directed table, random strings with periodic drains
	initial begin
		int next_drain;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.text_byte <= 8'h00;
		byte_ch.last_byte <= 1'b0;
		byte_ch.empty_string <= 1'b0;
		clear_scan();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_ROWS; i++)
			put_beat(PROBES[i].ch, PROBES[i].fin, PROBES[i].nul, PROBES[i].known_ok,
				PROBES[i].want_ok);
		// empty beat with every ignored bit set closes the aborted string
		put_beat(8'hff, 1'b1, 1'b1, 1'b1, 1'b0);
		drain_verdicts();

		next_drain = beats_sent + DRAIN_EVERY;
		while (beats_sent < PROBE_ROWS + 1 + RANDOM_BEATS) begin
			send_random_string();
			if (beats_sent >= next_drain) begin
				drain_verdicts();
				next_drain = beats_sent + DRAIN_EVERY;
			end
		end

		drain_verdicts();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d byte beats; checked %0d verdicts, %0d plain and %0d quoted",
			beats_sent, verdicts_seen, plain_seen, verdicts_seen - plain_seen);
		$display("covered every reject rule, markers, aborted strings and random stalls");
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
